@@ src/spf_pkg.sv @@
// Shared types, codes and helper functions of the scanline polygon filler.
`default_nettype none
package spf_pkg;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_POINT = 2'd1;
    localparam logic [1:0] CMD_ROW   = 2'd2;

    localparam logic [2:0] REG_SCALE_X = 3'd0;
    localparam logic [2:0] REG_SCALE_Y = 3'd1;
    localparam logic [2:0] REG_OFF_X   = 3'd2;
    localparam logic [2:0] REG_OFF_Y   = 3'd3;
    localparam logic [2:0] REG_COLOUR  = 3'd4;

    localparam logic signed [23:0] Q_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] Q_MIN = -24'sh800000;

    localparam int SPAN_CNT_W = 6;
    localparam logic [SPAN_CNT_W-1:0] SPAN_LIMIT = 6'd32;
    localparam int DIV_STEPS = 25;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic               new_subpath;
    } in_item_t;

    typedef struct packed {
        logic               span_valid;
        logic signed [15:0] span_row;
        logic signed [15:0] start_x;
        logic signed [15:0] end_x;
        logic [31:0]        span_colour;
        logic               last_of_row;
        logic               path_done;
        logic               overflow;
    } out_item_t;

    typedef struct packed {
        logic               start;
        logic signed [23:0] x;
        logic signed [23:0] y;
    } point_t;

    typedef struct packed {
        logic signed [15:0] col;
        logic               up;
    } cross_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_PT_X, ST_PT_Y, ST_PT_WR, ST_ROW_INIT, ST_EMPTY,
        ST_FIRST_RD, ST_FIRST_LD, ST_EDGE_RD, ST_EDGE, ST_MUL, ST_DIV,
        ST_CROSS, ST_INS_RD, ST_INS_CMP, ST_SPAN_INIT, ST_SPAN_RD, ST_SPAN,
        ST_FINAL
    } state_t;

    // floor(prod / 2^16) + off, saturated to Q16.8
    function automatic logic signed [23:0] map_coord(input logic signed [49:0] prod,
                                                     input logic signed [23:0] off);
        logic signed [34:0] sum;
        sum = 35'($signed(prod[49:16])) + 35'(off);
        if (sum > 35'(Q_MAX))
            return Q_MAX;
        else if (sum < 35'(Q_MIN))
            return Q_MIN;
        else
            return sum[23:0];
    endfunction

    // divide by 256, rounding toward zero
    function automatic logic signed [15:0] trunc8(input logic signed [25:0] v);
        logic [25:0] m;
        m = v[25] ? 26'(-v) : 26'(v);
        m = m >> 8;
        return v[25] ? 16'(-m[15:0]) : m[15:0];
    endfunction

endpackage
`default_nettype wire

@@ src/spf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module spf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ src/scanline_polygon_fill_top.sv @@
// Top level of the scanline polygon filler (non-zero winding).
`default_nettype none
// Stores up to MAX_POINTS polyline points and fills the polygon one pixel row per
// row transaction. An add-point transaction has the shared 25x25 multiplier
// scale x, then y, and then writes the point to the point RAM. A row transaction
// walks every stored edge: an edge that misses the row is read and tested, and
// one that crosses it goes through the multiplier and the 25-step restoring
// divider, and each crossing is inserted in x order into the crossing RAM as it
// is found, shifting every stored entry with a larger column up by one; for C
// crossings in a row at most C*(C-1)/2 entries are shifted. The spans are then
// read back one crossing at a time, and the read-back waits while the result
// side stalls. s_ready is low while a transaction is at work. Results leave
// through an output register, so the last result of a row may wait there while
// the next transaction is taken. There is no clearing pass; reading back only
// what was written makes one unnecessary. Config writes are always accepted and
// must only be made while the block is idle.
module scanline_polygon_fill_top #(
    parameter int MAX_POINTS = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire spf_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output spf_pkg::out_item_t      m_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    import spf_pkg::*;

    localparam int PAW   = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int XDEP  = MAX_POINTS - 1;
    localparam int XAW   = $clog2(XDEP);
    localparam int WND_W = PAW + 1;

    state_t state_reg, state_next;

    // configuration
    logic [23:0]        scale_x_reg, scale_y_reg;
    logic signed [23:0] off_x_reg, off_y_reg;
    logic [31:0]        colour_reg;

    // path state
    logic [CNT_W-1:0]   count_reg, count_next;
    logic signed [23:0] min_y_reg, min_y_next, max_y_reg, max_y_next;
    logic signed [15:0] row_reg, row_next;
    logic               started_reg, started_next;
    logic               ovf_reg, ovf_next;
    logic               done_reg, done_next;

    // working registers
    in_item_t           in_reg, in_next;
    logic signed [49:0] mul_reg;
    logic signed [23:0] x_reg, x_next;
    point_t             prev_reg, prev_next, cur_reg, cur_next;
    logic [PAW-1:0]     idx_reg, idx_next, n_reg, n_next, j_reg, j_next, i_reg, i_next;
    logic [23:0]        dymag_reg, dymag_next;
    logic               dyneg_reg, dyneg_next, dir_reg, dir_next, neg_reg, neg_next;
    logic [23:0]        rem_reg, rem_next;
    logic [24:0]        quo_reg, quo_next;
    logic [4:0]         step_reg, step_next;
    cross_t             key_reg, key_next;
    logic signed [WND_W-1:0] wind_reg, wind_next;
    logic signed [15:0] fill_reg, fill_next;
    logic [SPAN_CNT_W-1:0] scnt_reg, scnt_next;
    logic               pend_v_reg, pend_v_next;
    logic signed [15:0] pend_s_reg, pend_s_next, pend_e_reg, pend_e_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    // shared multiplier
    logic signed [24:0] mul_a, mul_b;

    // memories
    logic               pt_we;
    point_t             pt_wdata, pt_rdata;
    logic               x_we;
    logic [XAW-1:0]     x_waddr, x_raddr;
    cross_t             x_wdata, x_rdata;

    logic               in_acc, out_free;
    logic signed [23:0] s_line;
    logic               edge_hit, span_close, span_open;
    logic signed [WND_W-1:0] wind_new;
    logic               last_edge;
    logic signed [24:0] dy;
    logic [49:0]        num_mag;
    logic [24:0]        trial;
    logic               trial_ge;
    logic signed [25:0] q_s, x_cross;
    logic signed [15:0] row_first;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign in_acc    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign s_line    = {row_reg, 8'h00};
    assign edge_hit  = (prev_reg.y < s_line && pt_rdata.y >= s_line)
                    || (pt_rdata.y < s_line && prev_reg.y >= s_line);
    assign dy        = 25'(pt_rdata.y) - 25'(prev_reg.y);
    assign last_edge = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign num_mag   = mul_reg[49] ? 50'(-mul_reg) : 50'(mul_reg);
    assign trial     = {rem_reg, quo_reg[24]};
    assign trial_ge  = trial >= {1'b0, dymag_reg};
    assign q_s       = neg_reg ? -26'({1'b0, quo_reg}) : 26'({1'b0, quo_reg});
    assign x_cross   = 26'(prev_reg.x) + q_s;
    assign row_first = started_reg ? row_reg : trunc8(26'(min_y_reg));

    assign wind_new   = x_rdata.up ? wind_reg + WND_W'(1) : wind_reg - WND_W'(1);
    assign span_close = (wind_reg != '0) && (wind_new == '0) && (scnt_reg < SPAN_LIMIT);
    assign span_open  = (wind_reg == '0) && (wind_new != '0);

    always_comb begin
        case (state_reg)
            ST_PT_X: begin
                mul_a = 25'(in_reg.point_x);
                mul_b = {1'b0, scale_x_reg};
            end
            ST_PT_Y: begin
                mul_a = 25'(in_reg.point_y);
                mul_b = {1'b0, scale_y_reg};
            end
            default: begin
                mul_a = 25'(s_line) - 25'(prev_reg.y);
                mul_b = 25'(pt_rdata.x) - 25'(prev_reg.x);
            end
        endcase
    end

    spf_ram #(.WIDTH($bits(point_t)), .DEPTH(MAX_POINTS)) u_pt_ram (
        .clk  (aclk),
        .we   (pt_we),
        .waddr(count_reg[PAW-1:0]),
        .wdata(pt_wdata),
        .raddr(idx_reg),
        .rdata(pt_rdata)
    );

    spf_ram #(.WIDTH($bits(cross_t)), .DEPTH(XDEP)) u_x_ram (
        .clk  (aclk),
        .we   (x_we),
        .waddr(x_waddr),
        .wdata(x_wdata),
        .raddr(x_raddr),
        .rdata(x_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    case (s_data.command)
                        CMD_POINT: state_next = (count_reg >= CNT_W'(MAX_POINTS)) ?
                                                ST_IDLE : ST_PT_X;
                        CMD_ROW:   state_next = ST_ROW_INIT;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PT_X:     state_next = ST_PT_Y;
            ST_PT_Y:     state_next = ST_PT_WR;
            ST_PT_WR:    state_next = ST_IDLE;
            ST_ROW_INIT: state_next = (count_reg == '0) ? ST_EMPTY : ST_FIRST_RD;
            ST_EMPTY:    state_next = out_free ? ST_IDLE : ST_EMPTY;
            ST_FIRST_RD: state_next = ST_FIRST_LD;
            ST_FIRST_LD: state_next = (count_reg == CNT_W'(1)) ? ST_SPAN_INIT : ST_EDGE_RD;
            ST_EDGE_RD:  state_next = ST_EDGE;
            ST_EDGE: begin
                if (!pt_rdata.start && edge_hit)
                    state_next = ST_MUL;
                else
                    state_next = last_edge ? ST_SPAN_INIT : ST_EDGE_RD;
            end
            ST_MUL:      state_next = ST_DIV;
            ST_DIV:      state_next = (step_reg == 5'(DIV_STEPS - 1)) ? ST_CROSS : ST_DIV;
            ST_CROSS:    state_next = ST_INS_RD;
            ST_INS_RD: begin
                if (j_reg != '0)
                    state_next = ST_INS_CMP;
                else
                    state_next = last_edge ? ST_SPAN_INIT : ST_EDGE_RD;
            end
            ST_INS_CMP: begin
                if (x_rdata.col > key_reg.col)
                    state_next = ST_INS_RD;
                else
                    state_next = last_edge ? ST_SPAN_INIT : ST_EDGE_RD;
            end
            ST_SPAN_INIT: state_next = (n_reg == '0) ? ST_FINAL : ST_SPAN_RD;
            ST_SPAN_RD:   state_next = ST_SPAN;
            ST_SPAN: begin
                if (!(span_close && pend_v_reg && !out_free))
                    state_next = ((i_reg + PAW'(1)) == n_reg) ? ST_FINAL : ST_SPAN_RD;
            end
            ST_FINAL:     state_next = out_free ? ST_IDLE : ST_FINAL;
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        count_next   = count_reg;
        min_y_next   = min_y_reg;
        max_y_next   = max_y_reg;
        row_next     = row_reg;
        started_next = started_reg;
        ovf_next     = ovf_reg;
        done_next    = done_reg;
        in_next      = in_reg;
        x_next       = x_reg;
        prev_next    = prev_reg;
        cur_next     = cur_reg;
        idx_next     = idx_reg;
        n_next       = n_reg;
        j_next       = j_reg;
        i_next       = i_reg;
        dymag_next   = dymag_reg;
        dyneg_next   = dyneg_reg;
        dir_next     = dir_reg;
        neg_next     = neg_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        step_next    = step_reg;
        key_next     = key_reg;
        wind_next    = wind_reg;
        fill_next    = fill_reg;
        scnt_next    = scnt_reg;
        pend_v_next  = pend_v_reg;
        pend_s_next  = pend_s_reg;
        pend_e_next  = pend_e_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        pt_we        = 1'b0;
        pt_wdata     = '0;
        x_we         = 1'b0;
        x_waddr      = j_reg[XAW-1:0];
        x_wdata      = key_reg;
        x_raddr      = (state_reg == ST_SPAN_RD || state_reg == ST_SPAN) ?
                       i_reg[XAW-1:0] : XAW'(j_reg - PAW'(1));

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    in_next = s_data;
                    case (s_data.command)
                        CMD_CLEAR: begin
                            count_next   = '0;
                            min_y_next   = Q_MAX;
                            max_y_next   = Q_MIN;
                            row_next     = '0;
                            started_next = 1'b0;
                            ovf_next     = 1'b0;
                        end
                        CMD_POINT: begin
                            if (count_reg >= CNT_W'(MAX_POINTS))
                                ovf_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PT_Y: x_next = map_coord(mul_reg, off_x_reg);
            ST_PT_WR: begin
                pt_we          = 1'b1;
                pt_wdata.start = (count_reg == '0) || in_reg.new_subpath;
                pt_wdata.x     = x_reg;
                pt_wdata.y     = map_coord(mul_reg, off_y_reg);
                if (pt_wdata.y < min_y_reg) min_y_next = pt_wdata.y;
                if (pt_wdata.y > max_y_reg) max_y_next = pt_wdata.y;
                count_next = count_reg + CNT_W'(1);
            end
            ST_ROW_INIT: begin
                if (count_reg != '0) begin
                    row_next     = row_first;
                    started_next = 1'b1;
                    done_next    = row_first >= trunc8(26'(max_y_reg));
                end
                n_next   = '0;
                idx_next = '0;
            end
            ST_EMPTY: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next.last_of_row = 1'b1;
                    m_data_next.path_done   = 1'b1;
                    m_data_next.overflow    = ovf_reg;
                end
            end
            ST_FIRST_LD: begin
                prev_next = pt_rdata;
                idx_next  = PAW'(1);
            end
            ST_EDGE: begin
                cur_next   = pt_rdata;
                dyneg_next = dy[24];
                dymag_next = dy[24] ? 24'(-dy) : dy[23:0];
                dir_next   = prev_reg.y < pt_rdata.y;
                if (pt_rdata.start || !edge_hit) begin
                    prev_next = pt_rdata;
                    if (!last_edge) idx_next = idx_reg + PAW'(1);
                end
            end
            ST_MUL: begin
                neg_next  = mul_reg[49] ^ dyneg_reg;
                rem_next  = {1'b0, num_mag[47:25]};
                quo_next  = num_mag[24:0];
                step_next = '0;
            end
            ST_DIV: begin
                rem_next  = trial_ge ? 24'(trial - {1'b0, dymag_reg}) : trial[23:0];
                quo_next  = {quo_reg[23:0], trial_ge};
                step_next = step_reg + 5'd1;
            end
            ST_CROSS: begin
                key_next.col = trunc8(x_cross);
                key_next.up  = dir_reg;
                j_next       = n_reg;
            end
            ST_INS_RD: begin
                if (j_reg == '0) begin
                    x_we      = 1'b1;
                    n_next    = n_reg + PAW'(1);
                    prev_next = cur_reg;
                    if (!last_edge) idx_next = idx_reg + PAW'(1);
                end
            end
            ST_INS_CMP: begin
                x_we = 1'b1;
                if (x_rdata.col > key_reg.col) begin
                    x_wdata = x_rdata;
                    j_next  = j_reg - PAW'(1);
                end else begin
                    n_next    = n_reg + PAW'(1);
                    prev_next = cur_reg;
                    if (!last_edge) idx_next = idx_reg + PAW'(1);
                end
            end
            ST_SPAN_INIT: begin
                i_next      = '0;
                wind_next   = '0;
                scnt_next   = '0;
                pend_v_next = 1'b0;
            end
            ST_SPAN: begin
                if (!(span_close && pend_v_reg && !out_free)) begin
                    wind_next = wind_new;
                    i_next    = i_reg + PAW'(1);
                    if (span_open) fill_next = x_rdata.col;
                    if (span_close) begin
                        if (pend_v_reg) begin
                            m_valid_next = 1'b1;
                            m_data_next  = '{span_valid: 1'b1, span_row: row_reg,
                                             start_x: pend_s_reg, end_x: pend_e_reg,
                                             span_colour: colour_reg, last_of_row: 1'b0,
                                             path_done: done_reg, overflow: ovf_reg};
                        end
                        pend_v_next = 1'b1;
                        pend_s_next = fill_reg;
                        pend_e_next = x_rdata.col;
                        scnt_next   = scnt_reg + SPAN_CNT_W'(1);
                    end
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (pend_v_reg)
                        m_data_next = '{span_valid: 1'b1, span_row: row_reg,
                                        start_x: pend_s_reg, end_x: pend_e_reg,
                                        span_colour: colour_reg, last_of_row: 1'b1,
                                        path_done: done_reg, overflow: ovf_reg};
                    else
                        m_data_next = '{span_valid: 1'b0, span_row: row_reg,
                                        start_x: '0, end_x: '0, span_colour: '0,
                                        last_of_row: 1'b1, path_done: done_reg,
                                        overflow: ovf_reg};
                    if (done_reg) begin
                        started_next = 1'b0;
                        row_next     = '0;
                    end else begin
                        row_next = row_reg + 16'sd1;
                    end
                end
            end
            default: ;
        endcase
    end

    // control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            scale_x_reg <= 24'd65536;
            scale_y_reg <= 24'd65536;
            off_x_reg   <= '0;
            off_y_reg   <= '0;
            colour_reg  <= '0;
            count_reg   <= '0;
            min_y_reg   <= Q_MAX;
            max_y_reg   <= Q_MIN;
            row_reg     <= '0;
            started_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            min_y_reg   <= min_y_next;
            max_y_reg   <= max_y_next;
            row_reg     <= row_next;
            started_reg <= started_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SCALE_X: scale_x_reg <= cfg_data[23:0];
                    REG_SCALE_Y: scale_y_reg <= cfg_data[23:0];
                    REG_OFF_X:   off_x_reg   <= cfg_data[23:0];
                    REG_OFF_Y:   off_y_reg   <= cfg_data[23:0];
                    REG_COLOUR:  colour_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        mul_reg    <= mul_a * mul_b;
        in_reg     <= in_next;
        done_reg   <= done_next;
        x_reg      <= x_next;
        prev_reg   <= prev_next;
        cur_reg    <= cur_next;
        idx_reg    <= idx_next;
        n_reg      <= n_next;
        j_reg      <= j_next;
        i_reg      <= i_next;
        dymag_reg  <= dymag_next;
        dyneg_reg  <= dyneg_next;
        dir_reg    <= dir_next;
        neg_reg    <= neg_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        step_reg   <= step_next;
        key_reg    <= key_next;
        wind_reg   <= wind_next;
        fill_reg   <= fill_next;
        scnt_reg   <= scnt_next;
        pend_v_reg <= pend_v_next;
        pend_s_reg <= pend_s_next;
        pend_e_reg <= pend_e_next;
        m_data_reg <= m_data_next;
    end

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_data.command == CMD_POINT && count_reg == CNT_W'(MAX_POINTS))
        |=> (ovf_reg && count_reg == CNT_W'(MAX_POINTS)))
        else $error("dropped point did not flag overflow");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < dymag_reg))
        else $error("divider remainder not below divisor");

    a_cross_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SPAN || state_reg == ST_FINAL) |-> (CNT_W'(n_reg) < count_reg))
        else $error("more crossings than edges");

    a_span_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SPAN || state_reg == ST_FINAL) |-> (scnt_reg <= SPAN_LIMIT))
        else $error("span count over limit");

endmodule
`default_nettype wire

@@ tb/spf_checker.sv @@
// Span predictor and result checker for the scanline polygon filler.
`timescale 1ns / 100ps
module spf_checker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire spf_pkg::in_item_t  s_data,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire spf_pkg::out_item_t m_data,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output int                      errors,
    output int                      spans_pending
);
    import spf_pkg::*;

    localparam int NPTS = 64;
    localparam int SPANS_PER_ROW = 32;

    int unsigned  sc_x = 65536, sc_y = 65536;
    int           off_x = 0, off_y = 0;
    logic [31:0]  colour = '0;

    int           pt_x [NPTS];
    int           pt_y [NPTS];
    bit           pt_start [NPTS];
    int           pt_cnt = 0;
    int           y_lo = int'(Q_MAX), y_hi = int'(Q_MIN);
    int           row_now = 0;
    bit           walking = 0;
    bit           dropped = 0;

    out_item_t    span_q [$];

    initial errors = 0;
    initial spans_pending = 0;

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int map_pt(input int p, input int unsigned sc, input int off);
        longint v;
        v = (longint'(p) * longint'(sc)) >>> 16;
        v = v + longint'(off);
        if (v > longint'(Q_MAX)) v = longint'(Q_MAX);
        if (v < longint'(Q_MIN)) v = longint'(Q_MIN);
        return int'(v);
    endfunction

    function automatic out_item_t make_span(input bit vld, input int row, input int sx,
                                            input int ex, input logic [31:0] c,
                                            input bit last, input bit done);
        out_item_t e;
        e.span_valid  = vld;
        e.span_row    = row[15:0];
        e.start_x     = sx[15:0];
        e.end_x       = ex[15:0];
        e.span_colour = c;
        e.last_of_row = last;
        e.path_done   = done;
        e.overflow    = dropped;
        return e;
    endfunction

    task automatic predict_row();
        int  col [NPTS];
        int  dir [NPTS];
        int  n, k, wind, fstart, row, last_row, j, kc, kd;
        bit  done, was_in;
        longint s, y1, y2, num, xx;
        n = 0; k = 0; wind = 0; fstart = -1;
        if (pt_cnt == 0) begin
            span_q.insert(span_q.size(), make_span(0, 0, 0, 0, '0, 1, 1));
            return;
        end
        if (!walking) begin
            row_now = y_lo / 256;
            walking = 1;
        end
        row = row_now;
        last_row = y_hi / 256;
        s = longint'(row) * 256;
        for (int i = 0; i + 1 < pt_cnt; i++) begin
            if (pt_start[i+1]) continue;
            y1 = pt_y[i];
            y2 = pt_y[i+1];
            if ((y1 < s && y2 >= s) || (y2 < s && y1 >= s)) begin
                num = (s - y1) * (longint'(pt_x[i+1]) - longint'(pt_x[i]));
                xx = longint'(pt_x[i]) + num / (y2 - y1);
                col[n] = int'(xx / 256);
                dir[n] = (y1 < y2) ? 1 : -1;
                n++;
            end
        end
        // stable insertion sort by column
        for (int i = 1; i < n; i++) begin
            kc = col[i]; kd = dir[i]; j = i;
            while (j > 0 && col[j-1] > kc) begin
                col[j] = col[j-1]; dir[j] = dir[j-1]; j--;
            end
            col[j] = kc; dir[j] = kd;
        end
        done = (row >= last_row);
        for (int i = 0; i < n; i++) begin
            was_in = (wind != 0);
            wind += dir[i];
            if (was_in && wind == 0 && k < SPANS_PER_ROW) begin
                span_q.insert(span_q.size(), make_span(1, row, fstart, col[i], colour, 0, done));
                k++;
            end
            if (!was_in && wind != 0) fstart = col[i];
        end
        if (k == 0) begin
            span_q.insert(span_q.size(), make_span(0, row, 0, 0, '0, 1, done));
        end else begin
            span_q[span_q.size()-1].last_of_row = 1;
        end
        if (done) begin
            walking = 0;
            row_now = 0;
        end else begin
            row_now = row + 1;
        end
    endtask

    task automatic apply_item(input in_item_t it);
        case (it.command)
            CMD_CLEAR: begin
                pt_cnt = 0; y_lo = int'(Q_MAX); y_hi = int'(Q_MIN);
                row_now = 0; walking = 0; dropped = 0;
            end
            CMD_POINT: begin
                if (pt_cnt >= NPTS) begin
                    dropped = 1;
                end else begin
                    pt_x[pt_cnt] = map_pt(int'(it.point_x), sc_x, off_x);
                    pt_y[pt_cnt] = map_pt(int'(it.point_y), sc_y, off_y);
                    pt_start[pt_cnt] = (pt_cnt == 0) || it.new_subpath;
                    if (pt_y[pt_cnt] < y_lo) y_lo = pt_y[pt_cnt];
                    if (pt_y[pt_cnt] > y_hi) y_hi = pt_y[pt_cnt];
                    pt_cnt++;
                end
            end
            CMD_ROW: predict_row();
            default: ;
        endcase
    endtask

    task automatic check_span(input out_item_t got);
        out_item_t exp;
        if (span_q.size() == 0) begin
            report($sformatf("unexpected span transaction %h", got));
            return;
        end
        exp = span_q.pop_front();
        if (got.span_valid !== exp.span_valid)
            report($sformatf("span_valid %0d exp %0d", got.span_valid, exp.span_valid));
        if (got.span_row !== exp.span_row)
            report($sformatf("span_row %0d exp %0d", got.span_row, exp.span_row));
        if (got.start_x !== exp.start_x)
            report($sformatf("start_x %0d exp %0d", got.start_x, exp.start_x));
        if (got.end_x !== exp.end_x)
            report($sformatf("end_x %0d exp %0d", got.end_x, exp.end_x));
        if (got.span_colour !== exp.span_colour)
            report($sformatf("span_colour %h exp %h", got.span_colour, exp.span_colour));
        if (got.last_of_row !== exp.last_of_row)
            report($sformatf("last_of_row %0d exp %0d", got.last_of_row, exp.last_of_row));
        if (got.path_done !== exp.path_done)
            report($sformatf("path_done %0d exp %0d", got.path_done, exp.path_done));
        if (got.overflow !== exp.overflow)
            report($sformatf("overflow %0d exp %0d", got.overflow, exp.overflow));
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            // results first: one leaving now belongs to an earlier row
            if (m_valid && m_ready) check_span(m_data);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SCALE_X: sc_x = {8'd0, cfg_data[23:0]};
                    REG_SCALE_Y: sc_y = {8'd0, cfg_data[23:0]};
                    REG_OFF_X:   off_x = int'($signed(cfg_data[23:0]));
                    REG_OFF_Y:   off_y = int'($signed(cfg_data[23:0]));
                    REG_COLOUR:  colour = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) apply_item(s_data);
            spans_pending = span_q.size();
        end
    end
endmodule

@@ tb/tb_scanline_polygon_fill_top.sv @@
// Stimulus, reset, clock and verdict for the scanline polygon filler.
`timescale 1ns / 100ps
module tb_scanline_polygon_fill_top;
    import spf_pkg::*;

    // command three is not decoded by the block and must be ignored
    localparam logic [1:0] CMD_IGNORED = 2'd3;
    localparam int STALL_LIMIT = 60000;
    localparam int RANDOM_ITEMS = 250;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int errors, spans_pending;
    int tx_idle = 0;     // percent of cycles the sender holds back
    int rx_stall = 0;    // percent of cycles the receiver stalls
    int items_sent = 0;
    int quiet_cycles = 0;

    scanline_polygon_fill_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    spf_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .spans_pending(spans_pending)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_stall);
    end

    // Watchdog: any transaction on any channel resets the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL scanline_polygon_fill_top");
            $finish;
        end
    end

    // One input transaction; valid stays up afterward unless a gap follows.
    task automatic send(input logic [1:0] cmd, input logic signed [23:0] x,
                        input logic signed [23:0] y, input logic ns);
        while ($urandom_range(0, 99) < tx_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{command: cmd, point_x: x, point_y: y, new_subpath: ns};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Drop valid and let every outstanding span drain, then a short
    // settle so a trailing point transaction has finished too.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (spans_pending != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    // valid is left high; the caller drops it after the last write
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_config(input logic [23:0] sx, input logic [23:0] sy,
                              input logic [23:0] ox, input logic [23:0] oy,
                              input logic [31:0] c);
        write_reg(REG_SCALE_X, {8'd0, sx});
        write_reg(REG_SCALE_Y, {8'd0, sy});
        write_reg(REG_OFF_X, {8'd0, ox});
        write_reg(REG_OFF_Y, {8'd0, oy});
        write_reg(REG_COLOUR, c);
        cfg_valid <= 1'b0;
    endtask

    // Mostly small coordinates (few rows, many crossings); sometimes any value.
    function automatic logic signed [23:0] rnd_coord();
        if ($urandom_range(0, 9) == 0)
            return 24'($urandom);
        return 24'(int'($urandom_range(0, 4095)) - 2048);
    endfunction

    // Well-formed path: clear, one or more polylines, then a walk of rows.
    task automatic random_path();
        int npts, nrows;
        npts = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(2, 12);
        nrows = $urandom_range(1, 8);
        send(CMD_CLEAR, rnd_coord(), rnd_coord(), 1'($urandom));
        for (int i = 0; i < npts; i++)
            send(CMD_POINT, rnd_coord(), rnd_coord(), ($urandom_range(0, 99) < 15));
        for (int i = 0; i < nrows; i++)
            send(CMD_ROW, rnd_coord(), rnd_coord(), 1'($urandom));
    endtask

    task automatic random_noise();
        send(2'($urandom), 24'($urandom), 24'($urandom), 1'($urandom));
    endtask

    initial begin
        int phase_end;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_config(24'h010000, 24'h010000, 24'h000000, 24'h000000, 32'hFF10_2030);

        // Directed: empty store, ignored command, rectangle with a closed outline,
        // single-point subpath, open subpath, walk past the last row.
        send(CMD_ROW, 24'sd0, 24'sd0, 1'b0);
        send(CMD_IGNORED, Q_MAX, Q_MIN, 1'b1);
        send(CMD_POINT, 24'sd0, 24'sd0, 1'b0);           // first point starts a subpath
        send(CMD_POINT, 24'sd2560, 24'sd0, 1'b0);
        send(CMD_POINT, 24'sd2560, 24'sd1024, 1'b0);
        send(CMD_POINT, 24'sd0, 24'sd1024, 1'b0);
        send(CMD_POINT, 24'sd0, 24'sd0, 1'b0);
        send(CMD_POINT, 24'sd500, 24'sd300, 1'b1);       // lone point, no edge
        send(CMD_POINT, -24'sd700, 24'sd900, 1'b1);      // open subpath, one edge
        send(CMD_POINT, -24'sd300, -24'sd200, 1'b0);
        for (int i = 0; i < 6; i++)
            send(CMD_ROW, 24'sd0, 24'sd0, 1'b0);
        send(CMD_CLEAR, 24'sd0, 24'sd0, 1'b0);
        // extremes sit at the range bounds; only a couple of the many rows are asked for
        send(CMD_POINT, Q_MAX, Q_MAX, 1'b0);
        send(CMD_POINT, Q_MIN, Q_MIN, 1'b0);
        send(CMD_POINT, Q_MAX, Q_MIN, 1'b1);
        send(CMD_POINT, Q_MIN, Q_MAX, 1'b0);
        send(CMD_ROW, 24'sd0, 24'sd0, 1'b0);
        send(CMD_ROW, 24'sd0, 24'sd0, 1'b0);
        drain();

        // Random phases, each with its own register setting and one of four idle modes.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin tx_idle = 0;  rx_stall = 0;  end
                1: begin tx_idle = 63; rx_stall = 0;  end
                2: begin tx_idle = 0;  rx_stall = 63; end
                default: begin tx_idle = 25; rx_stall = 25; end
            endcase
            case (ph)
                0: set_config(24'h000001, 24'hFFFFFF, 24'h800000, 24'h7FFFFF, 32'hFFFF_FFFF);
                1: set_config(24'hFFFFFF, 24'h000001, 24'h7FFFFF, 24'h800000, 32'h0000_0000);
                2: set_config(24'h020000, 24'h018000, 24'h000400, 24'hFFFC00, $urandom);
                3: set_config(24'h000000, 24'h000000, 24'($urandom), 24'($urandom), $urandom);
                4: set_config(24'h010000, 24'h010000, 24'h000000, 24'h000000, $urandom);
                default: set_config(24'($urandom_range(32768, 196608)),
                                    24'($urandom_range(32768, 196608)),
                                    24'(int'($urandom_range(0, 4095)) - 2048),
                                    24'(int'($urandom_range(0, 4095)) - 2048), $urandom);
            endcase
            phase_end = items_sent + RANDOM_ITEMS / 8;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 99) < 80)
                    random_path();
                else
                    random_noise();
            end
            drain();
        end

        // drain() already waited for the queue; give the output register time
        repeat (200) @(posedge aclk);
        if (errors == 0 && spans_pending == 0) begin
            $display("PASS scanline_polygon_fill_top");
        end else begin
            $display("FAIL scanline_polygon_fill_top");
        end
        $finish;
    end
endmodule
